// File: rtl/gbd_pkg.sv
// Package: types, constants and state codes of the grayscale box downscaler.
package gbd_pkg;

  localparam int MAX_SOURCE_WIDTH  = 1024;
  localparam int MAX_SOURCE_HEIGHT = 1024;
  localparam int MAX_TARGET_WIDTH  = 64;
  localparam int MAX_TARGET_SIDE   = 64;

  localparam int SRC_W   = 11;
  localparam int TGT_W   = 7;
  localparam int IDX_W   = $clog2(MAX_TARGET_WIDTH);
  localparam int SUM_W   = 28;
  localparam int AREA_W  = 21;
  localparam int CFG_W   = 11;

  localparam logic [SRC_W-1:0] SW_RST   = 11'd320;
  localparam logic [SRC_W-1:0] SH_RST   = 11'd240;
  localparam logic [TGT_W-1:0] TW_RST   = 7'd64;
  localparam logic [TGT_W-1:0] TH_RST   = 7'd48;
  localparam logic [SRC_W-1:0] STEP_RST = 11'd5;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVX,
    ST_DIVY,
    ST_GATE,
    ST_RD,
    ST_SUM,
    ST_DIVM,
    ST_EMIT,
    ST_ERR,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic [7:0] gray;
    logic [5:0] target_x;
    logic [5:0] target_y;
    logic       last_of_frame;
    logic       bad_config;
  } res_t;

  typedef struct packed {
    logic capture;
    logic frame_init;
    logic divx_start;
    logic latch_x;
    logic latch_y;
    logic mem_rd;
    logic sum_calc;
    logic sum_wr;
    logic load_res;
    logic load_err;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic run_ok;
    logic in_blk;
    logic blk_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/gbd_stream_if.sv
// Interfaces: source pixel channel and result channel.
interface gbd_pix_if;
  import gbd_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gbd_res_if;
  import gbd_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/grayscale_box_downscale.sv
// Top level of the grayscale box downscaler: controller, datapath and ports.
// A pixel past the last target row is dropped; one outside every block only advances the
// counters; one inside a block reads its column sum, adds itself and writes it back. A pixel
// that closes a block then waits on the iterative divider forming the mean and on a full
// output register; its result is valid the cycle after it is loaded. A frame-start pixel
// first runs the two step divisions; an unusable one yields an error. Pixels go one at a time.
// Reset (synchronous, active high) loads the default sizes, steps of 5, clears sum valid bits.
module grayscale_box_downscale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0] cfg_data,
  gbd_pix_if.sink                   pix_in,
  gbd_res_if.source                 res_out
);
  import gbd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  gbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_fs    (pix_in.data.frame_start),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (pix_in.ready)
  );

  gbd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_data  (pix_in.data),
    .cmd       (cmd),
    .sts       (sts),
    .res_out   (res_out)
  );

endmodule

// File: rtl/gbd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module gbd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gbd_pkg::SUM_W-1:0] dividend,
  input  logic [gbd_pkg::AREA_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [gbd_pkg::SUM_W-1:0] quotient
);
  import gbd_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic [AREA_W:0]   shifted;
  logic              fits;

  assign shifted = {rem, quotient[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? AREA_W'(shifted - {1'b0, dsr}) : shifted[AREA_W-1:0];
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

// File: rtl/gbd_datapath.sv
// Datapath: configuration, position counters, column sum memory, divider, output register.
module gbd_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0] cfg_data,
  input  gbd_pkg::pix_t             pix_data,
  input  gbd_pkg::ctrl_cmd_t        cmd,
  output gbd_pkg::dp_sts_t          sts,
  gbd_res_if.source                 res_out
);
  import gbd_pkg::*;

  logic [SRC_W-1:0] cfg_sw, cfg_sh;
  logic [TGT_W-1:0] cfg_tw, cfg_th;
  logic [SRC_W-1:0] lat_sw;
  logic [TGT_W-1:0] lat_tw, lat_th;
  logic [SRC_W-1:0] step_x, step_y;
  logic [AREA_W-1:0] area;
  logic             frame_ok;

  logic [SRC_W-1:0] source_col, row_in_band, col_in_block;
  logic [TGT_W-1:0] band_index, block_index;

  logic [7:0]       pix;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] sums [MAX_TARGET_WIDTH];
  logic [SUM_W-1:0] rdata;
  logic [MAX_TARGET_WIDTH-1:0] vld;
  logic [IDX_W-1:0] idx;

  logic             div_start, div_busy, div_done;
  logic [SUM_W-1:0] div_a, div_q;
  logic [AREA_W-1:0] div_b;

  logic cfg_ok, col_end, row_end, blk_done;
  res_t res;
  logic res_valid;

  assign idx = block_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sw <= SW_RST;
      cfg_sh <= SH_RST;
      cfg_tw <= TW_RST;
      cfg_th <= TH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SOURCE_WIDTH:  cfg_sw <= cfg_data;
        REG_SOURCE_HEIGHT: cfg_sh <= cfg_data;
        REG_TARGET_WIDTH:  cfg_tw <= cfg_data[TGT_W-1:0];
        REG_TARGET_HEIGHT: cfg_th <= cfg_data[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ok = (cfg_sw >= SRC_W'(1)) && (cfg_sw <= SRC_W'(MAX_SOURCE_WIDTH)) &&
                  (cfg_sh >= SRC_W'(1)) && (cfg_sh <= SRC_W'(MAX_SOURCE_HEIGHT)) &&
                  (cfg_tw >= TGT_W'(1)) && (cfg_tw <= TGT_W'(MAX_TARGET_SIDE)) &&
                  (cfg_tw <= TGT_W'(MAX_TARGET_WIDTH)) &&
                  (cfg_th >= TGT_W'(1)) && (cfg_th <= TGT_W'(MAX_TARGET_SIDE)) &&
                  ({4'b0, cfg_tw} <= cfg_sw) && ({4'b0, cfg_th} <= cfg_sh);

  assign div_start = cmd.divx_start | cmd.latch_x | (cmd.sum_wr & blk_done);

  always_comb begin
    if (cmd.divx_start) begin
      div_a = SUM_W'(cfg_sw);
      div_b = AREA_W'(cfg_tw);
    end else if (cmd.latch_x) begin
      div_a = SUM_W'(cfg_sh);
      div_b = AREA_W'(cfg_th);
    end else begin
      div_a = acc;
      div_b = area;
    end
  end

  gbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    area <= AREA_W'(step_x) * AREA_W'(step_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ok <= 1'b1;
      lat_sw   <= SW_RST;
      lat_tw   <= TW_RST;
      lat_th   <= TH_RST;
      step_x   <= STEP_RST;
      step_y   <= STEP_RST;
    end else if (cmd.frame_init) begin
      frame_ok <= cfg_ok;
      lat_sw   <= cfg_ok ? cfg_sw : '0;
      lat_tw   <= cfg_ok ? cfg_tw : '0;
      lat_th   <= cfg_ok ? cfg_th : '0;
      step_x   <= '0;
      step_y   <= '0;
    end else if (cmd.latch_x) begin
      step_x <= div_q[SRC_W-1:0];
    end else if (cmd.latch_y) begin
      step_y <= div_q[SRC_W-1:0];
    end
  end

  assign col_end  = ({1'b0, col_in_block} + 1'b1) == {1'b0, step_x};
  assign row_end  = ({1'b0, row_in_band} + 1'b1) == {1'b0, step_y};
  assign blk_done = sts.in_blk & col_end & row_end;

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_init) begin
      source_col   <= '0;
      row_in_band  <= '0;
      col_in_block <= '0;
      band_index   <= '0;
      block_index  <= '0;
    end else if (cmd.advance) begin
      if ({1'b0, source_col} + 1'b1 >= {1'b0, lat_sw}) begin
        source_col   <= '0;
        col_in_block <= '0;
        block_index  <= '0;
        if ({1'b0, row_in_band} + 1'b1 >= {1'b0, step_y}) begin
          row_in_band <= '0;
          band_index  <= band_index + 1'b1;
        end else begin
          row_in_band <= row_in_band + 1'b1;
        end
      end else begin
        source_col <= source_col + 1'b1;
        if (sts.in_blk) begin
          if (col_end) begin
            col_in_block <= '0;
            block_index  <= block_index + 1'b1;
          end else begin
            col_in_block <= col_in_block + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix <= pix_data.pixel;
    end
    if (cmd.sum_calc) begin
      acc <= (vld[idx] ? rdata : '0) + SUM_W'(pix);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) begin
      sums[idx] <= blk_done ? '0 : acc;
    end
    if (cmd.mem_rd) begin
      rdata <= sums[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_init) begin
      vld <= '0;
    end else if (cmd.sum_wr) begin
      vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_res || cmd.load_err) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      res <= '{gray: 8'd0, target_x: 6'd0, target_y: 6'd0,
               last_of_frame: 1'b1, bad_config: 1'b1};
    end else if (cmd.load_res) begin
      res.gray          <= div_q[7:0];
      res.target_x      <= block_index[5:0];
      res.target_y      <= band_index[5:0];
      res.last_of_frame <= (block_index + 1'b1 == lat_tw) && (band_index + 1'b1 == lat_th);
      res.bad_config    <= 1'b0;
    end
  end

  assign res_out.valid = res_valid;
  assign res_out.data  = res;

  assign sts.cfg_ok   = cfg_ok;
  assign sts.run_ok   = frame_ok && (band_index < lat_th);
  assign sts.in_blk   = block_index < lat_tw;
  assign sts.blk_done = blk_done;
  assign sts.div_done = div_done;
  assign sts.out_free = !res_valid || res_out.ready;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_res || cmd.load_err) |-> (!res_valid || res_out.ready))
    else $error("result loaded over a pending transaction");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.bad_config) |-> (res.last_of_frame && res.gray == 8'd0))
    else $error("error result with bad fields");
`endif

endmodule

// File: rtl/gbd_ctrl.sv
// Controller: state machine that sequences one transaction through the datapath.
module gbd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_fs,
  input  gbd_pkg::dp_sts_t    sts,
  output gbd_pkg::ctrl_cmd_t  cmd,
  output logic                in_ready
);
  import gbd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = in_fs ? ST_CHECK : ST_GATE;
      ST_CHECK: state_next = sts.cfg_ok ? ST_DIVX : ST_ERR;
      ST_DIVX:  if (sts.div_done) state_next = ST_DIVY;
      ST_DIVY:  if (sts.div_done) state_next = ST_GATE;
      ST_GATE: begin
        if (!sts.run_ok) state_next = ST_IDLE;
        else if (sts.in_blk) state_next = ST_RD;
        else state_next = ST_ADV;
      end
      ST_RD:    state_next = ST_SUM;
      ST_SUM:   state_next = sts.blk_done ? ST_DIVM : ST_ADV;
      ST_DIVM:  if (sts.div_done) state_next = ST_EMIT;
      ST_EMIT:  if (sts.out_free) state_next = ST_ADV;
      ST_ERR:   if (sts.out_free) state_next = ST_IDLE;
      ST_ADV:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: begin
        cmd.frame_init = 1'b1;
        cmd.divx_start = sts.cfg_ok;
      end
      ST_DIVX: cmd.latch_x  = sts.div_done;
      ST_DIVY: cmd.latch_y  = sts.div_done;
      ST_GATE: cmd.mem_rd   = sts.run_ok && sts.in_blk;
      ST_RD:   cmd.sum_calc = 1'b1;
      ST_SUM:  cmd.sum_wr   = 1'b1;
      ST_DIVM: ;
      ST_EMIT: cmd.load_res = sts.out_free;
      ST_ERR:  cmd.load_err = sts.out_free;
      ST_ADV:  cmd.advance  = 1'b1;
      default: ;
    endcase
  end

endmodule
